// ===== rtl/tts_pkg.sv =====
// Shared types and constants for the text terminal scroll engine.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package tts_pkg;

   // Default screen geometry in pixels
   localparam int SCREEN_W_DEF = 320;
   localparam int SCREEN_H_DEF = 240;

   // Reset character cell size
   localparam logic [5:0] CHAR_W_RESET = 6'd6;
   localparam logic [5:0] CHAR_H_RESET = 6'd8;

   // Configuration register indexes
   localparam logic [1:0] CSR_BG_COLOR    = 2'd0;
   localparam logic [1:0] CSR_CHAR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_CHAR_HEIGHT = 2'd2;

   // Display command codes
   localparam logic [1:0] CMD_SCROLL = 2'd0;
   localparam logic [1:0] CMD_FILL   = 2'd1;
   localparam logic [1:0] CMD_DRAW   = 2'd2;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_PRINT_LOW = 8'd32;

   // Queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // Classified character as it travels through the queue
   typedef struct packed {
      logic       is_newline;
      logic       is_print;
      logic [6:0] glyph;
   } tts_item_type;

endpackage

`default_nettype wire

// ===== rtl/tts_front.sv =====
// Front part: accepts character items, classifies them and buffers them
// in a two-entry queue for the back part. Uses tts_pkg.
`default_nettype none

module tts_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] char_code
   output tts_pkg::tts_item_type      item,
   output logic                       item_valid,
   input  wire logic                  item_pop
);

   tts_pkg::tts_item_type                slot_ff [tts_pkg::Q_DEPTH];
   logic [tts_pkg::Q_PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [tts_pkg::Q_PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [tts_pkg::Q_CNT_W-1:0]          count_ff, count_in;
   tts_pkg::tts_item_type                cls;
   logic                                 push;
   logic                                 pop;

   // Classify the incoming code
   always_comb begin
      cls.is_newline = (req_tdata == tts_pkg::CHAR_NEWLINE);
      cls.is_print   = !req_tdata[7] && (req_tdata >= tts_pkg::CHAR_PRINT_LOW);
      cls.glyph      = req_tdata[6:0];
   end

   assign req_tready = (count_ff != tts_pkg::Q_CNT_W'(tts_pkg::Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];

   // Pointers wrap naturally at the queue depth
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tts_back.sv =====
// Back part: keeps cursor and scroll state, plans up to three display
// commands per item and issues them one per cycle unless the output is stalled. Uses tts_pkg.
`default_nettype none

module tts_back #(
   parameter int SCREEN_W = tts_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = tts_pkg::SCREEN_H_DEF,
   parameter int VW       = $clog2(SCREEN_H + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  tts_pkg::tts_item_type      item,
   input  wire logic                  item_valid,
   output logic                       item_pop,
   input  wire logic [15:0]           bg_color,
   input  wire logic [5:0]            eff_w,
   input  wire logic [5:0]            eff_h,
   input  wire logic [VW-1:0]         usable_h,
   input  wire logic [VW-1:0]         last_top,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   // Column can reach the screen width, or one wide cell on a narrow screen
   localparam int COL_MAX = (SCREEN_W > 63) ? SCREEN_W : 63;
   localparam int CW      = $clog2(COL_MAX + 1);

   // Cursor and scroll state
   logic [CW-1:0]  col_ff, col_in;
   logic [VW-1:0]  row_ff, row_in;
   logic           scroll_on_ff, scroll_on_in;
   logic [VW-1:0]  offset_ff, offset_in;

   // Plan: bit 0 scroll, bit 1 fill, bit 2 draw
   logic [2:0]     pend_ff, pend_in;
   logic [7:0]     plan_ss_ff, plan_ss_in;
   logic [7:0]     plan_y_ff, plan_y_in;
   logic [8:0]     plan_x_ff, plan_x_in;
   logic [6:0]     plan_glyph_ff, plan_glyph_in;
   logic [15:0]    plan_color_ff, plan_color_in;

   // Output register
   logic           out_valid_ff, out_valid_in;
   logic [1:0]     out_cmd_ff, out_cmd_in;
   logic [8:0]     out_x_ff, out_x_in;
   logic [7:0]     out_y_ff, out_y_in;
   logic [7:0]     out_ss_ff, out_ss_in;
   logic [6:0]     out_glyph_ff, out_glyph_in;
   logic [15:0]    out_color_ff, out_color_in;
   logic           out_last_ff, out_last_in;

   // Item evaluation
   logic [CW:0]    col_sum;
   logic           wrap;
   logic [VW:0]    row_sum;
   logic           passed;
   logic           scroll_now;
   logic [VW-1:0]  base;
   logic [VW:0]    off_sum;
   logic [VW-1:0]  off_new;
   logic [VW-1:0]  row_new;
   logic [VW-1:0]  row_cur;
   logic [CW-1:0]  col_wr;
   logic           out_free;
   logic           take;

   always_comb begin
      col_sum    = (CW+1)'(col_ff) + (CW+1)'(eff_w);
      wrap       = item.is_newline || (col_sum > (CW+1)'(SCREEN_W));
      row_sum    = (VW+1)'(row_ff) + (VW+1)'(eff_h);
      passed     = row_sum > (VW+1)'(last_top);
      scroll_now = scroll_on_ff || passed;
      // First scroll starts from line 0
      base       = (passed && !scroll_on_ff) ? '0 : offset_ff;
      off_sum    = (VW+1)'(base) + (VW+1)'(eff_h);
      off_new    = (off_sum >= (VW+1)'(usable_h)) ? '0 : VW'(off_sum);
      row_new    = passed ? '0 : VW'(row_sum);
      row_cur    = wrap ? row_new : row_ff;
      col_wr     = wrap ? '0 : col_ff;
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign take     = out_free && (pend_ff != '0);
   // Next item enters once the plan is empty or its last command leaves
   assign item_pop = item_valid && ((pend_ff == '0) || (take && $onehot(pend_ff)));

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      scroll_on_in = scroll_on_ff;
      offset_in    = offset_ff;
      // Clear lowest pending command when it moves out
      pend_in      = take ? (pend_ff & (pend_ff - 3'd1)) : pend_ff;
      plan_ss_in    = plan_ss_ff;
      plan_y_in     = plan_y_ff;
      plan_x_in     = plan_x_ff;
      plan_glyph_in = plan_glyph_ff;
      plan_color_in = plan_color_ff;
      if (item_pop) begin
         if (wrap) begin
            row_in       = row_new;
            scroll_on_in = scroll_now;
            if (scroll_now) begin
               offset_in = off_new;
            end
         end
         col_in = item.is_print ? CW'((CW+1)'(col_wr) + (CW+1)'(eff_w)) : col_wr;
         pend_in       = {item.is_print, wrap && scroll_now, wrap && scroll_now};
         plan_ss_in    = 8'(32'(off_new));
         plan_y_in     = 8'(32'(row_cur));
         plan_x_in     = 9'(32'(col_wr));
         plan_glyph_in = item.glyph;
         plan_color_in = bg_color;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_cmd_in   = out_cmd_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_ss_in    = out_ss_ff;
      out_glyph_in = out_glyph_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (take) begin
         out_valid_in = 1'b1;
         out_last_in  = $onehot(pend_ff);
         out_x_in     = '0;
         out_y_in     = '0;
         out_ss_in    = '0;
         out_glyph_in = '0;
         out_color_in = '0;
         if (pend_ff[0]) begin
            out_cmd_in = tts_pkg::CMD_SCROLL;
            out_ss_in  = plan_ss_ff;
         end else if (pend_ff[1]) begin
            out_cmd_in   = tts_pkg::CMD_FILL;
            out_y_in     = plan_y_ff;
            out_color_in = plan_color_ff;
         end else begin
            out_cmd_in   = tts_pkg::CMD_DRAW;
            out_x_in     = plan_x_ff;
            out_y_in     = plan_y_ff;
            out_glyph_in = plan_glyph_ff;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         scroll_on_ff <= 1'b0;
         offset_ff    <= '0;
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         scroll_on_ff <= scroll_on_in;
         offset_ff    <= offset_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ss_ff    <= plan_ss_in;
      plan_y_ff     <= plan_y_in;
      plan_x_ff     <= plan_x_in;
      plan_glyph_ff <= plan_glyph_in;
      plan_color_ff <= plan_color_in;
      out_cmd_ff    <= out_cmd_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_ss_ff     <= out_ss_in;
      out_glyph_ff  <= out_glyph_in;
      out_color_ff  <= out_color_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_cmd_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_color_ff, out_glyph_ff, out_ss_ff, out_y_ff, out_x_ff};

endmodule

`default_nettype wire

// ===== rtl/text_terminal_scroll_engine.sv =====
// Path: an accepted character passes the queue slot, the plan register and the output register.
// Flow: the back part plans 0..3 commands per character and takes the next character
//   when the last of them moves to the output register, or at once if there are none.
//   The two-entry queue lets characters be accepted while commands are issued.
// Reset (synchronous, active high): cursor, scroll state, queue and output valid
//   clear; bg_color 0, char width 6, char height 8, usable height from the table.
`default_nettype none

module text_terminal_scroll_engine #(
   parameter int SCREEN_W = tts_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = tts_pkg::SCREEN_H_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // Character input
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,    // [7:0] char_code
   // Display command output
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [47:0]        rsp_tdata,    // [8:0] pos_x, [16:9] pos_y,
                                            // [24:17] scroll_start, [31:25] glyph,
                                            // [47:32] fill_color
   output logic [1:0]         rsp_tuser,    // [1:0] command
   output logic               rsp_tlast,    // last command of this character
   // Configuration writes
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_addr,
   input  wire logic [15:0]   csr_wdata
);

   // Vertical positions, offsets and heights all stay within 0..SCREEN_H
   localparam int VW = $clog2(SCREEN_H + 1);

   // Usable height per raw char_height code, built at elaboration.
   // A zero height acts as one; a height above the screen is clamped.
   logic [VW-1:0] usable_tbl [64];

   assign usable_tbl[0] = VW'(SCREEN_H);
   for (genvar Hc = 1; Hc < 64; Hc++) begin : g_usable
      localparam int Eff    = (Hc > SCREEN_H) ? SCREEN_H : Hc;
      localparam int Usable = (SCREEN_H / Eff) * Eff;
      assign usable_tbl[Hc] = VW'(Usable);
   end

   logic [15:0]   bg_ff, bg_in;
   logic [5:0]    eff_w_ff, eff_w_in;
   logic [5:0]    eff_h_ff, eff_h_in;
   logic [VW-1:0] usable_ff, usable_in;
   logic [VW-1:0] last_top_ff, last_top_in;

   logic [5:0]    wr_code;
   logic [5:0]    wr_h;

   tts_pkg::tts_item_type item;
   logic                  item_valid;
   logic                  item_pop;

   // Height as written: zero acts as one, clamp to the screen
   always_comb begin
      wr_code = csr_wdata[5:0];
      wr_h    = (wr_code == '0) ? 6'd1 : wr_code;
      if (32'(wr_h) > SCREEN_H) begin
         wr_h = 6'(SCREEN_H);
      end
   end

   always_comb begin
      bg_in       = bg_ff;
      eff_w_in    = eff_w_ff;
      eff_h_in    = eff_h_ff;
      usable_in   = usable_ff;
      last_top_in = last_top_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tts_pkg::CSR_BG_COLOR: begin
               bg_in = csr_wdata;
            end
            tts_pkg::CSR_CHAR_WIDTH: begin
               eff_w_in = (wr_code == '0) ? 6'd1 : wr_code;
            end
            tts_pkg::CSR_CHAR_HEIGHT: begin
               eff_h_in    = wr_h;
               usable_in   = usable_tbl[wr_code];
               last_top_in = usable_tbl[wr_code] - VW'(wr_h);
            end
            default: begin
               // unused index, write ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff       <= '0;
         eff_w_ff    <= tts_pkg::CHAR_W_RESET;
         eff_h_ff    <= tts_pkg::CHAR_H_RESET;
         usable_ff   <= usable_tbl[tts_pkg::CHAR_H_RESET];
         last_top_ff <= usable_tbl[tts_pkg::CHAR_H_RESET] - VW'(tts_pkg::CHAR_H_RESET);
      end else begin
         bg_ff       <= bg_in;
         eff_w_ff    <= eff_w_in;
         eff_h_ff    <= eff_h_in;
         usable_ff   <= usable_in;
         last_top_ff <= last_top_in;
      end
   end

   // Front: accept, classify, queue
   tts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   // Back: cursor/scroll update and command sequencing
   tts_back #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H),
      .VW       (VW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .bg_color   (bg_ff),
      .eff_w      (eff_w_ff),
      .eff_h      (eff_h_ff),
      .usable_h   (usable_ff),
      .last_top   (last_top_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/tts_checker.sv =====
// Port-level checks for text_terminal_scroll_engine, attached by bind.
// Uses tts_pkg for command codes.
`default_nettype none

module tts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // Nothing is offered right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("command offered right after reset");

   // A scroll start is never marked last; a fill of the same character follows it
   a_scroll_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tts_pkg::CMD_SCROLL) |-> !rsp_tlast)
      else $error("scroll command marked last");

   // A draw is always the final command of its character
   a_draw_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == tts_pkg::CMD_DRAW) |-> rsp_tlast)
      else $error("draw command not marked last");

   // Stalled command holds
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled command changed");

endmodule

bind text_terminal_scroll_engine tts_checker u_tts_checker (.*);

`default_nettype wire
